### hw/rtl/phcb_pkg.sv
package phcb_pkg;

	// Philox 4x32 multipliers and Weyl key increments.
	localparam logic [31:0] MUL_A  = 32'hD251_1F53;
	localparam logic [31:0] MUL_B  = 32'hCD9E_8D57;
	localparam logic [31:0] WEYL_A = 32'h9E37_79B9;
	localparam logic [31:0] WEYL_B = 32'hBB67_AE85;

	// Counter words 0..3 and key words 0..1, index 0 is the low word.
	typedef logic [3:0][31:0] ctr_t;
	typedef logic [1:0][31:0] key_t;

endpackage

### hw/rtl/phcb_round.sv
// One Philox round as a pipeline stage. The incoming key is the base key; the Weyl bump
// for this round is a constant folded in here.
module phcb_round #(
	parameter int RIDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  phcb_pkg::ctr_t  in_ctr,
	input  phcb_pkg::key_t  in_key,
	output logic            out_valid,
	input  logic            out_ready,
	output phcb_pkg::ctr_t  out_ctr,
	output phcb_pkg::key_t  out_key
);

	localparam logic [63:0] BUMP_A_W = 64'(RIDX) * 64'(phcb_pkg::WEYL_A);
	localparam logic [63:0] BUMP_B_W = 64'(RIDX) * 64'(phcb_pkg::WEYL_B);
	localparam logic [31:0] BUMP_A   = BUMP_A_W[31:0];
	localparam logic [31:0] BUMP_B   = BUMP_B_W[31:0];

	logic            vld_s1;
	phcb_pkg::ctr_t  ctr_s1;
	phcb_pkg::key_t  key_s1;
	logic [63:0]     pa;
	logic [63:0]     pb;
	logic [31:0]     k0;
	logic [31:0]     k1;
	phcb_pkg::ctr_t  nxt;

	assign in_ready = !vld_s1 || out_ready;

	always_comb begin
		pa     = 64'(phcb_pkg::MUL_A) * 64'(in_ctr[0]);
		pb     = 64'(phcb_pkg::MUL_B) * 64'(in_ctr[2]);
		k0     = in_key[0] + BUMP_A;
		k1     = in_key[1] + BUMP_B;
		nxt[0] = pb[63:32] ^ in_ctr[1] ^ k0;
		nxt[1] = pb[31:0];
		nxt[2] = pa[63:32] ^ in_ctr[3] ^ k1;
		nxt[3] = pa[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctr_s1 <= nxt;
			key_s1 <= in_key;
		end
	end

	assign out_valid = vld_s1;
	assign out_ctr   = ctr_s1;
	assign out_key   = key_s1;

endmodule

### hw/rtl/philox_counter_block_generator_unit.sv
// Philox 4x32 counter block generator.
// Input channel: draw_index, stream_num and offset_value with in_valid / in_stall; a
// transfer happens on a clock edge with in_valid high and in_stall low. The index and the
// stream number form the 128-bit counter; the offset is folded into the key with the seed.
// Output channel: word0..word3 with out_valid / out_stall, one result per input transfer,
// in order.
// Configuration: seed_we writes seed_wdata into the seed register; write it only while no
// item is in flight. Reset clears the seed to zero and empties the pipeline.
// The pipeline is one stage for the key products, one for the seed add, and one stage per
// round, each holding one 32x32 multiplier pair. Throughput is one block per clock while
// out_stall is low. Every stage has its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles close up. When the receiver stalls, results pile up one per
// stage and in_stall rises only once all stages hold data; nothing is lost or repeated.
module philox_counter_block_generator_unit #(
	parameter int ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [63:0] seed_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] draw_index,
	input  logic [63:0] stream_num,
	input  logic [63:0] offset_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] word0,
	output logic [31:0] word1,
	output logic [31:0] word2,
	output logic [31:0] word3
);

	logic [63:0] seed_q;

	// Stage 1: key products. Since (a*W + b*W) mod 2^32 equals ((a+b)*W) mod 2^32, key word
	// one needs just one multiplier.
	logic            vld_s1;
	logic            rdy_s1;
	phcb_pkg::ctr_t  ctr_s1;
	logic [31:0]     prod_a_s1;
	logic [31:0]     prod_b_s1;
	logic [31:0]     off_sum;
	logic [63:0]     prod_a_w;
	logic [63:0]     prod_b_w;

	// Stage 2: base key = seed + products.
	logic            vld_s2;
	logic            rdy_s2;
	phcb_pkg::ctr_t  ctr_s2;
	phcb_pkg::key_t  key_s2;

	// Round chain. Element r feeds round r; the last element is the output stage.
	logic            rnd_vld [ROUNDS+1];
	logic            rnd_rdy [ROUNDS+1];
	phcb_pkg::ctr_t  rnd_ctr [ROUNDS+1];
	phcb_pkg::key_t  rnd_key [ROUNDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (seed_we) begin
			seed_q <= seed_wdata;
		end
	end

	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign rdy_s2   = !vld_s2 || rnd_rdy[0];
	assign in_stall = !rdy_s1;

	always_comb begin
		off_sum  = offset_value[31:0] + offset_value[63:32];
		prod_a_w = 64'(offset_value[31:0]) * 64'(phcb_pkg::WEYL_A);
		prod_b_w = 64'(off_sum) * 64'(phcb_pkg::WEYL_B);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			ctr_s1[0] <= draw_index[31:0];
			ctr_s1[1] <= draw_index[63:32];
			ctr_s1[2] <= stream_num[31:0];
			ctr_s1[3] <= stream_num[63:32];
			prod_a_s1 <= prod_a_w[31:0];
			prod_b_s1 <= prod_b_w[31:0];
		end
		if (rdy_s2 && vld_s1) begin
			ctr_s2    <= ctr_s1;
			key_s2[0] <= seed_q[31:0] + prod_a_s1;
			key_s2[1] <= seed_q[63:32] + prod_b_s1;
		end
	end

	assign rnd_vld[0] = vld_s2;
	assign rnd_ctr[0] = ctr_s2;
	assign rnd_key[0] = key_s2;

	// Round r applies the key bumped r times; the last round is never followed by a bump.
	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		if (r < ROUNDS - 1) begin : g_mid
			phcb_round #(
				.RIDX(r)
			) u_round (
				.clk      (clk),
				.arst_n   (arst_n),
				.in_valid (rnd_vld[r]),
				.in_ready (rnd_rdy[r]),
				.in_ctr   (rnd_ctr[r]),
				.in_key   (rnd_key[r]),
				.out_valid(rnd_vld[r+1]),
				.out_ready(rnd_rdy[r+1]),
				.out_ctr  (rnd_ctr[r+1]),
				.out_key  (rnd_key[r+1])
			);
		end else begin : g_last
			phcb_round #(
				.RIDX(r)
			) u_round (
				.clk      (clk),
				.arst_n   (arst_n),
				.in_valid (rnd_vld[r]),
				.in_ready (rnd_rdy[r]),
				.in_ctr   (rnd_ctr[r]),
				.in_key   (rnd_key[r]),
				.out_valid(rnd_vld[r+1]),
				.out_ready(rnd_rdy[r+1]),
				.out_ctr  (rnd_ctr[r+1]),
				.out_key  ()
			);
		end
	end

	// The last round's register is the output register.
	assign rnd_rdy[ROUNDS] = !out_stall;
	assign out_valid       = rnd_vld[ROUNDS];
	assign word0           = rnd_ctr[ROUNDS][0];
	assign word1           = rnd_ctr[ROUNDS][1];
	assign word2           = rnd_ctr[ROUNDS][2];
	assign word3           = rnd_ctr[ROUNDS][3];

endmodule
